@@ sv/bia_pkg.sv @@
`timescale 1ns / 1ps
package bia_pkg;

	localparam int ID_COUNT  = 1024;
	localparam int WORD_BITS = 32;
	localparam int ID_WORDS  = ID_COUNT / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int PTR_W     = $clog2(ID_WORDS);
	localparam int ID_W      = $clog2(ID_COUNT);
	localparam int CNT_W     = $clog2(ID_COUNT + 1);

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NONE   = 2'd1,
		ST_DOUBLE = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_DONE
	} fsm_t;

	// word store access, driven by the engine
	typedef struct packed {
		logic                 we;
		logic [PTR_W-1:0]     waddr;
		logic [WORD_BITS-1:0] wdata;
		logic [PTR_W-1:0]     raddr;
	} ram_req_t;

	// lowest free bit of the word under scan
	typedef struct packed {
		logic [BIT_W-1:0]     idx;
		logic [WORD_BITS-1:0] mask;
	} pick_t;

endpackage

@@ sv/bia_ram.sv @@
`timescale 1ns / 1ps
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/bia_bit_pick.sv @@
`timescale 1ns / 1ps
module bia_bit_pick (
	input  logic [bia_pkg::WORD_BITS-1:0] word,
	output bia_pkg::pick_t                pick
);
	import bia_pkg::*;

	logic [WORD_BITS-1:0] lsb;
	logic [BIT_W-1:0]     idx;

	// isolate lowest set bit, then encode its position
	assign lsb = word & (~word + WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lsb[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
	end

	assign pick.idx  = idx;
	assign pick.mask = lsb;

endmodule

@@ sv/bia_engine.sv @@
`timescale 1ns / 1ps
module bia_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bia_pkg::op_t                  in_op,
	input  logic [bia_pkg::ID_W-1:0]      in_rid,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bia_pkg::status_t              out_status,
	output logic [bia_pkg::ID_W-1:0]      out_id,
	output logic [bia_pkg::CNT_W-1:0]     out_in_use,
	output bia_pkg::ram_req_t             ram_req,
	input  logic [bia_pkg::WORD_BITS-1:0] ram_rdata,
	output logic [bia_pkg::WORD_BITS-1:0] scan_word,
	input  bia_pkg::pick_t                pick
);
	import bia_pkg::*;

	fsm_t                 state_q, state_d;
	op_t                  op_q;
	logic [ID_W-1:0]      rid_q;
	logic [PTR_W-1:0]     ptr_q, ptr_d, ptr_inc;
	logic [PTR_W-1:0]     scan_q, scan_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	status_t              res_status_q, res_status_d;
	logic [ID_W-1:0]      res_id_q, res_id_d;
	logic [ID_WORDS-1:0]  wr_valid_q;
	logic                 rd_valid_s1;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ID_W-1:0]      out_id_q;
	logic [CNT_W-1:0]     out_in_use_q;
	logic                 accept;
	logic                 load_out;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] rel_mask;
	logic [PTR_W-1:0]     rel_word;

	// never-written words read as all free
	assign word      = rd_valid_s1 ? ram_rdata : '1;
	assign scan_word = word;
	assign ptr_inc   = ptr_q + PTR_W'(1);
	assign rel_word  = rid_q[ID_W-1:BIT_W];
	assign rel_mask  = WORD_BITS'(1) << rid_q[BIT_W-1:0];
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		load_out      = 1'b0;
		ptr_d         = ptr_q;
		scan_d        = scan_q;
		cnt_d         = cnt_q;
		res_status_d  = res_status_q;
		res_id_d      = res_id_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = ptr_q;
		ram_req.wdata = word;
		ram_req.raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				ram_req.raddr = (in_op == OP_FREE) ? in_rid[ID_W-1:BIT_W] : ptr_q;
				scan_d        = '0;
				res_status_d  = ST_OK;
				res_id_d      = '0;
				if (in_valid) begin
					if (in_op == OP_ALLOC && cnt_q == '0) begin
						res_status_d = ST_NONE;
						state_d      = S_DONE;
					end else begin
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				if (op_q == OP_FREE) begin
					if ((word & rel_mask) != '0) begin
						res_status_d = ST_DOUBLE;
					end else begin
						ram_req.we    = 1'b1;
						ram_req.waddr = rel_word;
						ram_req.wdata = word | rel_mask;
						cnt_d         = cnt_q + CNT_W'(1);
					end
					state_d = S_DONE;
				end else if (word == '0) begin
					// skip a full word, fetch the next one
					ptr_d         = ptr_inc;
					scan_d        = scan_q + PTR_W'(1);
					ram_req.raddr = ptr_inc;
					if (scan_q == PTR_W'(ID_WORDS - 1)) begin
						res_status_d = ST_NONE;
						state_d      = S_DONE;
					end
				end else begin
					ram_req.we    = 1'b1;
					ram_req.waddr = ptr_q;
					ram_req.wdata = word & ~pick.mask;
					res_id_d      = ID_W'({ptr_q, pick.idx});
					cnt_d         = cnt_q - CNT_W'(1);
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			scan_q       <= '0;
			cnt_q        <= CNT_W'(ID_COUNT);
			wr_valid_q   <= '0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			ptr_q       <= ptr_d;
			scan_q      <= scan_d;
			cnt_q       <= cnt_d;
			rd_valid_s1 <= wr_valid_q[ram_req.raddr];
			if (ram_req.we) begin
				wr_valid_q[ram_req.waddr] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		if (accept) begin
			op_q  <= in_op;
			rid_q <= in_rid;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_in_use_q <= CNT_W'(ID_COUNT) - cnt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_in_use = out_in_use_q;

endmodule

@@ sv/bitmap_id_allocator_core.sv @@
`timescale 1ns / 1ps
// Identifier allocator over a free bitmap of 32 words by 32 bits (1 = free), with every
// identifier free after reset; no clearing pass is needed, since a word never written
// reads as all free. Send an allocate (tuser 0) or a free of tdata (tuser 1) as one
// input transaction; each one answers with exactly one output transaction carrying the
// status, the granted identifier (zero unless an allocate succeeded) and the count in
// use afterwards. An allocate scans the word store one word per cycle, a pace set by the
// single read port of the word store, from the word it last granted from, wrapping,
// until it finds a free bit. A free looks up only the word of its identifier, and an
// allocate with nothing free answers without a scan. The block takes one transaction
// at a time and holds tready low while it works; a finished result waits in the output
// register.
module bitmap_id_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] release_id, rest zero
	input  logic        s_axis_tuser,   // [0] op: 0 allocate, 1 free
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [9:0] granted_id, [20:10] in_use, rest zero
	output logic [1:0]  m_axis_tuser    // [1:0] status: 0 ok, 1 none free, 2 already free
);
	import bia_pkg::*;

	ram_req_t             ram_req;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [WORD_BITS-1:0] scan_word;
	pick_t                pick;
	status_t              out_status;
	logic [ID_W-1:0]      out_id;
	logic [CNT_W-1:0]     out_in_use;
	op_t                  in_op;

	assign in_op = op_t'(s_axis_tuser);

	// sequencer: accept, look up one word per cycle, update, respond
	bia_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (in_op),
		.in_rid     (s_axis_tdata[ID_W-1:0]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_id     (out_id),
		.out_in_use (out_in_use),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.scan_word  (scan_word),
		.pick       (pick)
	);

	// free bitmap, one word per entry
	bia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (ID_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// lowest free bit of the word under scan
	bia_bit_pick u_pick (
		.word (scan_word),
		.pick (pick)
	);

	assign m_axis_tdata = {3'b000, out_in_use, out_id};
	assign m_axis_tuser = out_status;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import bia_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 12;
	localparam int LONG_HOLD_OFF = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		op_t              op;
		logic [ID_W-1:0]  rid;
	} request_t;

	typedef struct {
		status_t          status;
		logic [ID_W-1:0]  granted;
		logic [CNT_W-1:0] in_use;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	bitmap_id_allocator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #HALF_PERIOD clk = ~clk;

	// shadow of the allocator: free bitmap (1 = free), next-fit word pointer, free count
	logic [WORD_BITS-1:0] free_words [ID_WORDS];
	logic [PTR_W-1:0]     scan_word;
	int unsigned          free_ids;

	request_t requests_todo[$];
	answer_t  answers_due[$];
	int       req_offered = 0;
	int       req_taken = 0;
	int       errors = 0;
	int       sender_idle_pct = 0;
	int       ready_stall_pct = 0;
	int       hold_off_asks = 0;
	int       hold_off_done = 0;
	int       hold_off_left = 0;
	int       quiet_cycles = 0;

	// Work out the answer to one accepted request and advance the shadow state.
	task automatic predict_answer(input op_t op, input logic [ID_W-1:0] rid);
		answer_t          ans;
		logic [PTR_W-1:0] wi;
		logic [BIT_W-1:0] bi;
		bit               found;
		ans.status = ST_OK;
		ans.granted = '0;
		found = 1'b0;
		if (op == OP_ALLOC) begin
			if (free_ids == 0) begin
				ans.status = ST_NONE;
			end else begin
				// skip fully taken words, wrapping, and take the lowest free bit of the first other one
				for (int n = 0; n < ID_WORDS && !found; n++) begin
					if (free_words[scan_word] == '0) begin
						scan_word = scan_word + 1'b1;
					end else begin
						for (int b = WORD_BITS - 1; b >= 0; b--) begin
							if (free_words[scan_word][b])
								bi = BIT_W'(b);
						end
						free_words[scan_word][bi] = 1'b0;
						ans.granted = {scan_word, bi};
						found = 1'b1;
					end
				end
				if (found)
					free_ids--;
				else
					ans.status = ST_NONE;
			end
		end else begin
			wi = rid[ID_W-1:BIT_W];
			bi = rid[BIT_W-1:0];
			// release of an identifier that is already free changes nothing
			if (free_words[wi][bi]) begin
				ans.status = ST_DOUBLE;
			end else begin
				free_words[wi][bi] = 1'b1;
				free_ids++;
			end
		end
		ans.in_use = CNT_W'(ID_COUNT - free_ids);
		answers_due.push_back(ans);
	endtask

	// Return an identifier the shadow holds as taken, or any one if none is taken.
	function automatic logic [ID_W-1:0] pick_busy_id();
		logic [ID_W-1:0] probe;
		probe = ID_W'($urandom_range(ID_COUNT - 1));
		for (int n = 0; n < ID_COUNT; n++) begin
			if (!free_words[probe[ID_W-1:BIT_W]][probe[BIT_W-1:0]])
				return probe;
			probe = probe + 1'b1;
		end
		return probe;
	endfunction

	// Keep only a short backlog so that picks of taken identifiers track the shadow closely.
	task automatic queue_request(input op_t op, input logic [ID_W-1:0] rid);
		request_t item;
		while (requests_todo.size() >= 2) begin
			@(posedge clk);
			#1;
		end
		item.op = op;
		item.rid = rid;
		requests_todo.push_back(item);
	endtask

	task automatic wait_all_answered();
		while (requests_todo.size() != 0 || req_taken != req_offered || answers_due.size() != 0) begin
			@(posedge clk);
			#1;
		end
	endtask

	task automatic queue_random_mix(input int count);
		int roll;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 55)
				queue_request(OP_ALLOC, ID_W'($urandom));
			else if (roll < 88)
				queue_request(OP_FREE, pick_busy_id());
			else
				queue_request(OP_FREE, ID_W'($urandom));
		end
	endtask

	// Sender: hold a transaction until taken, then offer the next one or idle.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (s_axis_tvalid && req_taken != req_offered) begin
			s_axis_tvalid <= 1'b1;
		end else if (requests_todo.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
			request_t item;
			item = requests_todo.pop_front();
			s_axis_tvalid <= 1'b1;
			s_axis_tuser <= item.op;
			s_axis_tdata <= {6'b0, item.rid};
			req_offered <= req_offered + 1;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is asked for.
	always @(negedge clk) begin
		if (hold_off_done != hold_off_asks) begin
			hold_off_done <= hold_off_asks;
			hold_off_left <= LONG_HOLD_OFF;
			m_axis_tready <= 1'b0;
		end else if (hold_off_left > 0) begin
			hold_off_left <= hold_off_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// Monitor: predict on every input transaction, check every output transaction.
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_answer(op_t'(s_axis_tuser), s_axis_tdata[ID_W-1:0]);
				req_taken = req_taken + 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.granted = m_axis_tdata[ID_W-1:0];
				got.in_use = m_axis_tdata[ID_W+CNT_W-1:ID_W];
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result: status %0d granted %0d in_use %0d",
						$time, got.status, got.granted, got.in_use);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (got.status != want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, got.status);
						errors++;
					end
					if (got.granted != want.granted) begin
						$display("%0t: granted_id mismatch: expected %0d, actual %0d",
							$time, want.granted, got.granted);
						errors++;
					end
					if (got.in_use != want.in_use) begin
						$display("%0t: in_use mismatch: expected %0d, actual %0d",
							$time, want.in_use, got.in_use);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		for (int w = 0; w < ID_WORDS; w++)
			free_words[w] = '1;
		scan_word = '0;
		free_ids = ID_COUNT;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed: both ops, release of a taken and of a free identifier, extreme field values
		queue_request(OP_ALLOC, '0);
		queue_request(OP_ALLOC, '1);
		queue_request(OP_FREE, 10'd0);
		queue_request(OP_FREE, 10'd0);
		queue_request(OP_FREE, 10'd1023);
		queue_request(OP_ALLOC, 10'h155);
		queue_request(OP_ALLOC, 10'h2AA);
		queue_request(OP_FREE, 10'd1);
		queue_request(OP_FREE, 10'h155);
		queue_request(OP_FREE, 10'h2AA);
		queue_request(OP_ALLOC, '0);
		queue_request(OP_FREE, 10'd2);
		queue_request(OP_FREE, 10'd0);
		queue_request(OP_FREE, 10'd31);
		queue_request(OP_FREE, 10'd32);

		for (int phase = 0; phase < 4; phase++) begin
			wait_all_answered();
			case (phase)
				0: begin
					sender_idle_pct = 0;
					ready_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 54;
					ready_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					ready_stall_pct = 54;
				end
				default: begin
					sender_idle_pct = 37;
					ready_stall_pct = 37;
				end
			endcase
			queue_random_mix(60);
			if (phase == 0)
				hold_off_asks++;
			if (phase == 1) begin
				// drain, punch scattered holes, then allocate into them
				wait_all_answered();
				repeat (48) queue_request(OP_FREE, pick_busy_id());
				repeat (30) queue_request(OP_ALLOC, ID_W'($urandom));
			end
			queue_random_mix(55);
		end

		wait_all_answered();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (answers_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, answers_due.size());
			errors++;
		end
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
sv/bia_pkg.sv
sv/bia_ram.sv
sv/bia_bit_pick.sv
sv/bia_engine.sv
sv/bitmap_id_allocator_core.sv
tb/sv/testbench.sv
